FILE: rtl/ldd_pkg.sv
// Shared types, widths, register codes and the quarter-wave sine table of
// the lock-in dither demodulator. No dependencies.
package ldd_pkg;

   localparam int ADC_W        = 12;
   localparam int DAC_W        = 16;
   localparam int LOCKIN_W     = 18;
   localparam int PHASE_W      = 16;
   localparam int COUNT_W      = 16;
   localparam int AMP_W        = 16;
   localparam int HARM_W       = 2;
   localparam int OFFSET_W     = 8;
   localparam int ACC_BITS     = 48;
   localparam int SINE_DEPTH   = 256;
   localparam int SINE_ADDR_W  = $clog2(SINE_DEPTH);
   localparam int SINE_W       = 16;
   localparam int POINT_SCALE  = 1920;
   localparam int SCALE_W      = 11;
   localparam int DIVISOR_W    = COUNT_W + SCALE_W;
   localparam int DIV_CNT_W    = $clog2(ACC_BITS);
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [LOCKIN_W-1:0] LOCKIN_MAX = 18'h1FFFF;
   localparam logic [LOCKIN_W-1:0] LOCKIN_MIN = 18'h20000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DITHER_AMPLITUDE  = 3'd0,
      CSR_PHASE_STEP        = 3'd1,
      CSR_HARMONIC          = 3'd2,
      CSR_DEMOD_OFFSET      = 3'd3,
      CSR_SAMPLES_PER_POINT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic busy;
   } div_status_type;

   // First quarter of a Q15 sine, 65 points including both ends.
   function automatic logic [14:0] quarter_wave(input logic [6:0] q);
      logic [14:0] v;
      unique case (q)
         7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1607;
         7'd3:  v = 15'd2410;  7'd4:  v = 15'd3211;  7'd5:  v = 15'd4011;
         7'd6:  v = 15'd4807;  7'd7:  v = 15'd5601;  7'd8:  v = 15'd6392;
         7'd9:  v = 15'd7179;  7'd10: v = 15'd7961;  7'd11: v = 15'd8739;
         7'd12: v = 15'd9511;  7'd13: v = 15'd10278; 7'd14: v = 15'd11038;
         7'd15: v = 15'd11792; 7'd16: v = 15'd12539; 7'd17: v = 15'd13278;
         7'd18: v = 15'd14009; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
         7'd21: v = 15'd16150; 7'd22: v = 15'd16845; 7'd23: v = 15'd17530;
         7'd24: v = 15'd18204; 7'd25: v = 15'd18867; 7'd26: v = 15'd19519;
         7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21402;
         7'd30: v = 15'd22004; 7'd31: v = 15'd22594; 7'd32: v = 15'd23169;
         7'd33: v = 15'd23731; 7'd34: v = 15'd24278; 7'd35: v = 15'd24811;
         7'd36: v = 15'd25329; 7'd37: v = 15'd25831; 7'd38: v = 15'd26318;
         7'd39: v = 15'd26789; 7'd40: v = 15'd27244; 7'd41: v = 15'd27683;
         7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28897;
         7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29955;
         7'd48: v = 15'd30272; 7'd49: v = 15'd30571; 7'd50: v = 15'd30851;
         7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
         7'd54: v = 15'd31785; 7'd55: v = 15'd31970; 7'd56: v = 15'd32137;
         7'd57: v = 15'd32284; 7'd58: v = 15'd32412; 7'd59: v = 15'd32520;
         7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32727;
         7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // Full-wave Q15 sine built from the quarter table by symmetry.
   function automatic logic signed [SINE_W-1:0] sine_value(
      input logic [SINE_ADDR_W-1:0] idx);
      logic [6:0]        q;
      logic [14:0]       mag;
      logic [SINE_W-1:0] ext;
      q   = idx[6:0];
      mag = (q <= 7'd64) ? quarter_wave(q) : quarter_wave(7'(8'd128 - {1'b0, q}));
      ext = {1'b0, mag};
      return idx[7] ? signed'(SINE_W'(-ext)) : signed'(ext);
   endfunction

endpackage

FILE: rtl/ldd_req_if.sv
// Input channel: one converter sample and sweep base per word.
// Depends on ldd_pkg.
interface ldd_req_if import ldd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADC_W-1:0]   adc_sample;
   logic [DAC_W-1:0]   sweep_base;

   modport source (output valid, adc_sample, sweep_base, input ready);
   modport sink   (input valid, adc_sample, sweep_base, output ready);
endinterface

FILE: rtl/ldd_rsp_if.sv
// Result channel: DAC code, lock-in result and status flags per word.
// Depends on ldd_pkg.
interface ldd_rsp_if import ldd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [DAC_W-1:0]           dac_value;
   logic signed [LOCKIN_W-1:0] lockin_value;
   logic                       lockin_done;
   logic [ADC_W-1:0]           adc_echo;
   logic                       adc_updated;
   logic                       phase_wrapped;

   modport source (output valid, dac_value, lockin_value, lockin_done, adc_echo,
                   adc_updated, phase_wrapped, input ready);
   modport sink   (input valid, dac_value, lockin_value, lockin_done, adc_echo,
                   adc_updated, phase_wrapped, output ready);
endinterface

FILE: rtl/ldd_csr_if.sv
// Configuration write channel: register index and write data per word.
// Depends on ldd_pkg.
interface ldd_csr_if import ldd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ldd_sine_rom.sv
// Synchronous Q15 sine ROM with one registered read port.
// Depends on ldd_pkg for the table function and widths.
module ldd_sine_rom import ldd_pkg::*; (
   input  logic                     clock,
   input  logic [SINE_ADDR_W-1:0]   addr,
   output logic signed [SINE_W-1:0] data_ff
);

   always_ff @(posedge clock) begin
      data_ff <= sine_value(addr);
   end

endmodule

FILE: rtl/ldd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ldd_pkg for widths and the status struct.
module ldd_divider import ldd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ACC_BITS-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output div_status_type         status,
   output logic [ACC_BITS-1:0]    quotient
);

   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIVISOR_W-1:0] div_ff;
   logic [ACC_BITS-1:0]  quo_ff;
   logic [ACC_BITS-1:0]  quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;

   // The dividend shifts out of the top of quo_ff as quotient bits shift in.
   always_comb begin
      trial = {rem_ff, quo_ff[ACC_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = diff[DIVISOR_W-1:0];
         quo_in = {quo_ff[ACC_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[ACC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(ACC_BITS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign status.busy = busy_ff;
   assign quotient    = quo_ff;

endmodule

FILE: rtl/lockin_dither_demodulator.sv
// Top level of the lock-in dither demodulator: sequencer, state registers and
// result staging. Depends on ldd_pkg, the three channel interfaces,
// ldd_sine_rom and ldd_divider.
//
//   Channel  Port    Direction  Word contents
//   input    req_if  sink       adc_sample, sweep_base
//   result   rsp_if  source     dac_value, lockin_value, lockin_done, adc_echo,
//                               adc_updated, phase_wrapped
//   config   csr_if  sink       index, data (always ready)
//
// A bypass word (zero amplitude) goes from ST_IDLE straight to ST_FINISH.
// A dither word makes two sequential reads of the single-port sine ROM, each
// followed by a registered multiply. A word that completes an integration
// period also waits for the divider, which works out the quotient bit by bit.
// Reset is synchronous and restores the register defaults and the state.
// A new input word is taken while the previous result still waits in the
// output register; the finished word stalls only until that register frees.
module lockin_dither_demodulator import ldd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ldd_req_if.sink    req_if,
   ldd_rsp_if.source  rsp_if,
   ldd_csr_if.sink    csr_if
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REF_READ,
      ST_REF_MAC,
      ST_ACC,
      ST_DAC_MUL,
      ST_DAC_SUM,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [AMP_W-1:0]    amplitude_ff;
   logic [PHASE_W-1:0]  phase_step_ff;
   logic [HARM_W-1:0]   harmonic_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [COUNT_W-1:0]  spp_ff;

   // Block state.
   logic [PHASE_W-1:0]         phase_ff;
   logic [ACC_BITS-1:0]        acc_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [LOCKIN_W-1:0] last_lockin_ff;
   logic [ADC_W-1:0]           reported_ff;

   // Captured input word and intermediate products.
   logic [ADC_W-1:0]        adc_ff;
   logic [DAC_W-1:0]        base_ff;
   logic signed [28:0]      prod_ff;
   logic signed [32:0]      dac_prod_ff;
   logic                    neg_ff;

   // Staged result fields, moved to the output register in ST_FINISH.
   logic [DAC_W-1:0] res_dac_ff;
   logic             res_done_ff;
   logic             res_upd_ff;
   logic             res_wrap_ff;

   // Output register.
   logic                       rsp_valid_ff;
   logic [DAC_W-1:0]           rsp_dac_ff;
   logic signed [LOCKIN_W-1:0] rsp_lockin_ff;
   logic                       rsp_done_ff;
   logic [ADC_W-1:0]           rsp_echo_ff;
   logic                       rsp_upd_ff;
   logic                       rsp_wrap_ff;

   // Datapath nets.
   logic [PHASE_W+HARM_W-1:0]  ref_phase;
   logic [OFFSET_W+HARM_W-1:0] ref_offset;
   logic [SINE_ADDR_W-1:0]     ref_idx;
   logic [PHASE_W-1:0]         phase_in;
   logic [SINE_ADDR_W-1:0]     rom_addr;
   logic signed [SINE_W-1:0]   rom_data;
   logic [ACC_BITS-1:0]        acc_in;
   logic [COUNT_W-1:0]         count_in;
   logic                       period_done;
   logic [COUNT_W-1:0]         spp_eff;
   logic [DIVISOR_W-1:0]       divisor;
   logic [ACC_BITS-1:0]        acc_mag;
   logic                       div_start;
   div_status_type             div_status;
   logic [ACC_BITS-1:0]        quotient;
   logic signed [LOCKIN_W-1:0] lockin_in;
   logic signed [LOCKIN_W-1:0] dither;
   logic signed [DAC_W+2:0]    dac_sum;
   logic [DAC_W-1:0]           dac_in;

   // Reference index: phase and offset both scale with the harmonic, each
   // wrapping at its own width before the two are added modulo the table.
   always_comb begin
      ref_phase  = phase_ff * harmonic_ff;
      ref_offset = offset_ff * harmonic_ff;
      ref_idx    = ref_phase[PHASE_W-1 -: SINE_ADDR_W] + ref_offset[SINE_ADDR_W-1:0];
      phase_in   = phase_ff + phase_step_ff;
      rom_addr   = (state_ff == ST_ACC) ? phase_in[PHASE_W-1 -: SINE_ADDR_W] : ref_idx;
   end

   // Accumulation and period check; a zero limit completes every sample.
   always_comb begin
      acc_in      = acc_ff + ACC_BITS'(prod_ff);
      count_in    = count_ff + 1'b1;
      period_done = (count_in >= spp_ff);
   end

   // The dividend is taken from the accumulator once it holds the sum
   // of the completed period.
   always_comb begin
      spp_eff   = (spp_ff == '0) ? COUNT_W'(1) : spp_ff;
      divisor   = spp_eff * SCALE_W'(POINT_SCALE);
      acc_mag   = acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : acc_ff;
      div_start = (state_ff == ST_DAC_MUL) && res_done_ff;
   end

   // The reported value is the negated average, so a negative sum gives a
   // positive result; both sides saturate to the 18-bit range.
   always_comb begin
      if (neg_ff) begin
         lockin_in = (quotient > ACC_BITS'(131071)) ? signed'(LOCKIN_MAX)
                                                    : signed'(quotient[LOCKIN_W-1:0]);
      end else begin
         lockin_in = (quotient > ACC_BITS'(131072)) ? signed'(LOCKIN_MIN)
                   : signed'(LOCKIN_W'(-quotient[LOCKIN_W-1:0]));
      end
   end

   // An arithmetic shift by 15 gives the floored division of the dither
   // product; the sum with the base then clamps to the DAC range.
   always_comb begin
      dither  = dac_prod_ff[32:15];
      dac_sum = signed'({3'b000, base_ff}) + (DAC_W+3)'(dither);
      if (dac_sum < 0) begin
         dac_in = '0;
      end else if (dac_sum > (DAC_W+3)'(65535)) begin
         dac_in = {DAC_W{1'b1}};
      end else begin
         dac_in = dac_sum[DAC_W-1:0];
      end
   end

   ldd_sine_rom u_sine_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_data)
   );

   ldd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         amplitude_ff   <= '0;
         phase_step_ff  <= '0;
         harmonic_ff    <= HARM_W'(1);
         offset_ff      <= OFFSET_W'(64);
         spp_ff         <= COUNT_W'(32);
         phase_ff       <= '0;
         acc_ff         <= '0;
         count_ff       <= '0;
         last_lockin_ff <= '0;
         reported_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            unique case (csr_index_type'(csr_if.index))
               CSR_DITHER_AMPLITUDE:  amplitude_ff  <= csr_if.data[AMP_W-1:0];
               CSR_PHASE_STEP:        phase_step_ff <= csr_if.data[PHASE_W-1:0];
               CSR_HARMONIC:          harmonic_ff   <= csr_if.data[HARM_W-1:0];
               CSR_DEMOD_OFFSET:      offset_ff     <= csr_if.data[OFFSET_W-1:0];
               CSR_SAMPLES_PER_POINT: spp_ff        <= csr_if.data[COUNT_W-1:0];
               default: ;
            endcase
         end

         // In ST_FINISH the output register is reloaded below instead.
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  adc_ff  <= req_if.adc_sample;
                  base_ff <= req_if.sweep_base;
                  if (amplitude_ff == '0) begin
                     // Bypass: only the reported reading changes.
                     reported_ff <= req_if.adc_sample;
                     res_dac_ff  <= req_if.sweep_base;
                     res_done_ff <= 1'b0;
                     res_upd_ff  <= 1'b1;
                     res_wrap_ff <= 1'b0;
                     state_ff    <= ST_FINISH;
                  end else begin
                     state_ff <= ST_REF_READ;
                  end
               end
            end
            ST_REF_READ: begin
               state_ff <= ST_REF_MAC;
            end
            ST_REF_MAC: begin
               prod_ff  <= signed'({1'b0, adc_ff}) * rom_data;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff      <= acc_in;
               count_ff    <= period_done ? '0 : count_in;
               phase_ff    <= phase_in;
               res_wrap_ff <= (phase_in < phase_ff);
               res_done_ff <= period_done;
               res_upd_ff  <= period_done;
               if (period_done) begin
                  reported_ff <= adc_ff;
               end
               state_ff <= ST_DAC_MUL;
            end
            ST_DAC_MUL: begin
               dac_prod_ff <= rom_data * signed'({1'b0, amplitude_ff});
               if (res_done_ff) begin
                  // The divider has latched the magnitude; start a new period.
                  neg_ff <= acc_ff[ACC_BITS-1];
                  acc_ff <= '0;
               end
               state_ff <= ST_DAC_SUM;
            end
            ST_DAC_SUM: begin
               res_dac_ff <= dac_in;
               state_ff   <= res_done_ff ? ST_DIV_WAIT : ST_FINISH;
            end
            ST_DIV_WAIT: begin
               if (!div_status.busy) begin
                  last_lockin_ff <= lockin_in;
                  state_ff       <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_dac_ff    <= res_dac_ff;
                  rsp_lockin_ff <= last_lockin_ff;
                  rsp_done_ff   <= res_done_ff;
                  rsp_echo_ff   <= reported_ff;
                  rsp_upd_ff    <= res_upd_ff;
                  rsp_wrap_ff   <= res_wrap_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.dac_value     = rsp_dac_ff;
   assign rsp_if.lockin_value  = rsp_lockin_ff;
   assign rsp_if.lockin_done   = rsp_done_ff;
   assign rsp_if.adc_echo      = rsp_echo_ff;
   assign rsp_if.adc_updated   = rsp_upd_ff;
   assign rsp_if.phase_wrapped = rsp_wrap_ff;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of lockin_dither_demodulator: a scoreboard class that predicts
// every result word from the accepted input words, plus code that drives the three channels.
// Depends on ldd_pkg, the ldd_req_if, ldd_rsp_if and ldd_csr_if interfaces, and the RTL top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ldd_pkg::*;

   // Scale applied per integrated sample: the divisor is samples times this.
   localparam int          SAMPLE_SCALE = 1920;
   localparam int          RANDOM_WORDS = 1000;
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   // A word that closes an integration period also waits for the divider;
   // this margin covers anything still in flight at the end of the run.
   localparam int          SETTLE_CYCLES = 80;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          PRINT_LIMIT   = 40;

   typedef struct {
      logic [DAC_W-1:0]           dac;
      logic signed [LOCKIN_W-1:0] lockin;
      logic                       done;
      logic [ADC_W-1:0]           echo;
      logic                       updated;
      logic                       wrapped;
   } result_word_type;

   // The scoreboard keeps its own copy of the demodulator state and register
   // settings, works out the result word for every accepted input word and
   // compares the words that come back, oldest expectation first.
   class lockin_scoreboard;
      logic [AMP_W-1:0]    amplitude;
      logic [PHASE_W-1:0]  step;
      logic [HARM_W-1:0]   harmonic;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  spp;

      logic [PHASE_W-1:0]  phase;
      logic [ACC_BITS-1:0] accum;
      logic [COUNT_W-1:0]  count;
      int                  last_lockin;
      logic [ADC_W-1:0]    reading;
      int                  sine_tab[SINE_DEPTH];

      result_word_type     pending_results[$];
      int                  errors;
      int                  checked;
      int                  periods;
      int                  bypass_words;

      function new();
         int quarter[65];
         int q;
         quarter = '{0, 804, 1607, 2410, 3211, 4011, 4807, 5601,
                     6392, 7179, 7961, 8739, 9511, 10278, 11038, 11792,
                     12539, 13278, 14009, 14732, 15446, 16150, 16845, 17530,
                     18204, 18867, 19519, 20159, 20787, 21402, 22004, 22594,
                     23169, 23731, 24278, 24811, 25329, 25831, 26318, 26789,
                     27244, 27683, 28105, 28510, 28897, 29268, 29621, 29955,
                     30272, 30571, 30851, 31113, 31356, 31580, 31785, 31970,
                     32137, 32284, 32412, 32520, 32609, 32678, 32727, 32757,
                     32767};
         for (int i = 0; i < SINE_DEPTH; i++) begin
            q = i % 128;
            sine_tab[i] = (q <= 64) ? quarter[q] : quarter[128 - q];
            if (i >= 128) begin
               sine_tab[i] = -sine_tab[i];
            end
         end
         amplitude    = '0;
         step         = '0;
         harmonic     = 2'd1;
         offset       = 8'd64;
         spp          = 16'd32;
         phase        = '0;
         accum        = '0;
         count        = '0;
         last_lockin  = 0;
         reading      = '0;
         errors       = 0;
         checked      = 0;
         periods      = 0;
         bypass_words = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DITHER_AMPLITUDE:  amplitude = data;
            CSR_PHASE_STEP:        step      = data;
            CSR_HARMONIC:          harmonic  = data[HARM_W-1:0];
            CSR_DEMOD_OFFSET:      offset    = data[OFFSET_W-1:0];
            CSR_SAMPLES_PER_POINT: spp       = data;
            default: ;
         endcase
      endfunction

      // Works out the result word of one accepted input word.
      function void note_word(logic [ADC_W-1:0] adc, logic [DAC_W-1:0] base);
         result_word_type     w;
         logic [PHASE_W-1:0]  pref;
         logic [PHASE_W-1:0]  prev;
         logic [7:0]          offs;
         logic [7:0]          idx;
         logic [ACC_BITS-1:0] mag;
         longint              prod;
         longint              p;
         longint              nxt;
         longint unsigned     divisor;
         longint unsigned     q;
         w.done    = 1'b0;
         w.wrapped = 1'b0;
         if (amplitude == 0) begin
            reading = adc;
            w.dac   = base;
            bypass_words++;
         end else begin
            // Reference at the chosen harmonic and offset, then integrate.
            pref  = 16'(int'(phase) * int'(harmonic));
            offs  = 8'(int'(offset) * int'(harmonic));
            idx   = pref[15:8] + offs;
            prod  = longint'(adc) * longint'(sine_tab[idx]);
            accum = accum + 48'(prod);
            count = count + 16'd1;
            if (count >= spp) begin
               divisor = ((spp == 0) ? 64'd1 : 64'(spp)) * SAMPLE_SCALE;
               mag     = accum[ACC_BITS-1] ? (~accum + 48'd1) : accum;
               q       = 64'(mag) / divisor;
               // The reported value is the negated average, saturated to 18 bits.
               if (accum[ACC_BITS-1]) begin
                  last_lockin = (q > 131071) ? 131071 : int'(q);
               end else begin
                  last_lockin = (q > 131072) ? -131072 : -int'(q);
               end
               reading = adc;
               w.done  = 1'b1;
               accum   = '0;
               count   = '0;
               periods++;
            end
            prev      = phase;
            phase     = phase + step;
            w.wrapped = (prev > phase);
            // Arithmetic shift gives the floor of the scaled dither.
            p   = longint'(sine_tab[phase[15:8]]) * longint'(amplitude);
            nxt = longint'(base) + (p >>> 15);
            if (nxt < 0) nxt = 0;
            if (nxt > 65535) nxt = 65535;
            w.dac = 16'(nxt);
         end
         w.lockin  = LOCKIN_W'(last_lockin);
         w.echo    = reading;
         w.updated = (amplitude == 0) || w.done;
         pending_results.push_back(w);
      endfunction

      task report_mismatch(string msg);
         if (errors < PRINT_LIMIT) begin
            $display("%0t ERROR: %s", $time, msg);
         end
         errors++;
      endtask

      task check_word(result_word_type got);
         result_word_type want;
         checked++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                      checked));
            return;
         end
         want = pending_results.pop_front();
         if (got.dac !== want.dac)
            report_mismatch($sformatf("word %0d dac_value %0d, expected %0d",
                                      checked, got.dac, want.dac));
         if (got.lockin !== want.lockin)
            report_mismatch($sformatf("word %0d lockin_value %0d, expected %0d",
                                      checked, got.lockin, want.lockin));
         if (got.done !== want.done)
            report_mismatch($sformatf("word %0d lockin_done %b, expected %b",
                                      checked, got.done, want.done));
         if (got.echo !== want.echo)
            report_mismatch($sformatf("word %0d adc_echo %0d, expected %0d",
                                      checked, got.echo, want.echo));
         if (got.updated !== want.updated)
            report_mismatch($sformatf("word %0d adc_updated %b, expected %b",
                                      checked, got.updated, want.updated));
         if (got.wrapped !== want.wrapped)
            report_mismatch($sformatf("word %0d phase_wrapped %b, expected %b",
                                      checked, got.wrapped, want.wrapped));
      endtask

      task finish_check();
         while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            report_mismatch("expected result word never arrived");
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ldd_req_if req_if ();
   ldd_rsp_if rsp_if ();
   ldd_csr_if csr_if ();

   lockin_dither_demodulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   lockin_scoreboard sb = new();

   // Set by the sender to ask the result side for one long hold-off.
   bit          hold_pending;
   bit          sender_calm;
   int          settings_loaded;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter: a run that has not finished by the limit has hung.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d result words outstanding.",
               cycle_count, sb.pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // Converter readings and sweep bases lean towards their end points so that
   // the zero and full-scale cases, and DAC saturation, come up often.
   function automatic logic [ADC_W-1:0] rand_adc();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return ADC_W'($urandom);
      endcase
   endfunction

   function automatic logic [DAC_W-1:0] rand_base();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DAC_W'($urandom_range(0, 255));
         3:       return DAC_W'(65535 - $urandom_range(0, 255));
         default: return DAC_W'($urandom);
      endcase
   endfunction

   // Offers one input word and holds it until the block takes it. The valid
   // line stays high; pause_sender or a drain lowers it when a gap follows.
   task automatic send_word(logic [ADC_W-1:0] adc, logic [DAC_W-1:0] base);
      req_if.valid      <= 1'b1;
      req_if.adc_sample <= adc;
      req_if.sweep_base <= base;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(adc, base);
   endtask

   task automatic pause_sender();
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering words and waits until every expected result has come back.
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
   endtask

   // Writes all five registers once the block has gone idle. The narrow
   // registers get random upper data bits, which the block must ignore.
   task automatic load_settings(input logic [AMP_W-1:0]    amp,
                                input logic [PHASE_W-1:0]  stp,
                                input logic [HARM_W-1:0]   harm,
                                input logic [OFFSET_W-1:0] offs,
                                input logic [COUNT_W-1:0]  spp);
      logic [CSR_DATA_W-1:0] hdat;
      logic [CSR_DATA_W-1:0] odat;
      hdat = CSR_DATA_W'($urandom);
      odat = CSR_DATA_W'($urandom);
      hdat[HARM_W-1:0]   = harm;
      odat[OFFSET_W-1:0] = offs;
      wait_results_drained();
      write_reg(CSR_DITHER_AMPLITUDE, amp);
      write_reg(CSR_PHASE_STEP, stp);
      write_reg(CSR_HARMONIC, hdat);
      write_reg(CSR_DEMOD_OFFSET, odat);
      write_reg(CSR_SAMPLES_PER_POINT, spp);
      csr_if.valid <= 1'b0;
      settings_loaded++;
   endtask

   // One random setting per phase, with the end points of every register but the
   // offset, and both bypass and the degenerate harmonic and period cases among them.
   // Periods are mostly short so that lock-in results come often.
   task automatic random_settings();
      logic [AMP_W-1:0]    amp;
      logic [PHASE_W-1:0]  stp;
      logic [HARM_W-1:0]   harm;
      logic [COUNT_W-1:0]  spp;
      int                  r;
      r = $urandom_range(0, 9);
      if (r == 0)      amp = '0;
      else if (r == 1) amp = '1;
      else if (r == 2) amp = AMP_W'($urandom_range(1, 15));
      else             amp = AMP_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)      stp = '0;
      else if (r == 1) stp = '1;
      else if (r == 2) stp = PHASE_W'($urandom_range(1, 300));
      else             stp = PHASE_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)      harm = 2'd0;
      else if (r == 1) harm = 2'd2;
      else if (r < 6)  harm = 2'd1;
      else             harm = 2'd3;
      r = $urandom_range(0, 19);
      if (r == 0)      spp = '0;
      else if (r == 1) spp = '1;
      else if (r == 2) spp = COUNT_W'($urandom_range(100, 1000));
      else             spp = COUNT_W'($urandom_range(1, 40));
      load_settings(amp, stp, harm, OFFSET_W'($urandom), spp);
   endtask

   // Result side: checks every word taken, stalls at random, and goes through
   // calm stretches in which only a hold-off stalls it. A hold-off asked for by the
   // sender keeps ready low for a long stretch so that the block backs up.
   initial begin : result_sink
      result_word_type got;
      int              stall;
      int              hold_left;
      int              mode_left;
      bit              calm;
      stall        = 0;
      hold_left    = 0;
      calm         = 1'b0;
      mode_left    = $urandom_range(200, 2000);
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.dac     = rsp_if.dac_value;
            got.lockin  = rsp_if.lockin_value;
            got.done    = rsp_if.lockin_done;
            got.echo    = rsp_if.adc_echo;
            got.updated = rsp_if.adc_updated;
            got.wrapped = rsp_if.phase_wrapped;
            sb.check_word(got);
         end
         mode_left--;
         if (mode_left <= 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(200, 2000);
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (calm) begin
            rsp_if.ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int random_words;
      int phase_no;
      int phase_len;
      random_words    = 0;
      phase_no        = 0;
      settings_loaded = 0;
      hold_pending    = 1'b0;
      sender_calm     = 1'b0;

      // Every input starts from a known value.
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.adc_sample <= '0;
      req_if.sweep_base <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_DITHER_AMPLITUDE;
      csr_if.data       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The reset settings select bypass: the reading is passed through and
      // the base goes out unchanged. Alternating patterns toggle every bit.
      send_word('0, '0);
      send_word('1, '1);
      send_word(12'hAAA, 16'h5555);
      send_word(12'h555, 16'hAAAA);

      // Full amplitude, a quarter cycle per sample and one sample per point:
      // the DAC code saturates at both ends, the reference swings through its
      // peaks, and the fourth word wraps the phase back to zero.
      load_settings('1, 16'd16384, 2'd1, 8'd64, 16'd1);
      send_word('1, '1);
      send_word('0, '0);
      send_word('1, '0);
      send_word('1, 16'd32768);

      // Harmonic zero pins the reference at the zero of the sine, and a zero
      // period length completes a period on every sample.
      load_settings(16'd500, '1, 2'd0, 8'd255, 16'd0);
      send_word(rand_adc(), rand_base());
      send_word(rand_adc(), rand_base());

      // Integrate a few full-scale samples against a positive reference under
      // a long period, then lower the period below the count: the next sample
      // closes the period and the result saturates at its negative end.
      load_settings(16'd1000, 16'd0, 2'd1, 8'd64, '1);
      repeat (6) send_word('1, rand_base());
      load_settings(16'd1000, 16'd0, 2'd1, 8'd64, 16'd1);
      send_word('1, rand_base());

      // The same against a negative reference saturates at the positive end.
      load_settings(16'd1000, 16'd0, 2'd1, 8'd192, '1);
      repeat (6) send_word('1, rand_base());
      load_settings(16'd1000, 16'd0, 2'd1, 8'd192, 16'd1);
      send_word('1, rand_base());

      // Random phases, each under its own setting. The counter and the
      // accumulator carry over between settings, so lowered period limits
      // come up here as well.
      while (random_words < RANDOM_WORDS) begin
         phase_no++;
         random_settings();
         sender_calm = ($urandom_range(0, 3) == 0);
         phase_len   = $urandom_range(60, 140);
         for (int i = 0; i < phase_len; i++) begin
            // In the second phase the result side holds off while words keep
            // coming, so the block fills up and stalls its input.
            if (phase_no == 2 && i == 30) begin
               hold_pending = 1'b1;
            end
            send_word(rand_adc(), rand_base());
            random_words++;
            // In the third phase the sender stops once until all is back.
            if (phase_no == 3 && i == 50) begin
               wait_results_drained();
            end else begin
               pause_sender();
            end
         end
      end

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.finish_check();

      $display("Covered %0d words under %0d settings: %0d in bypass, %0d periods closed.",
               sb.checked, settings_loaded + 1, sb.bypass_words, sb.periods);
      $display("Checked %0d result words in %0d cycles, %0d field mismatches.",
               sb.checked, cycle_count, sb.errors);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: lockin_dither_demodulator.f
rtl/ldd_pkg.sv
rtl/ldd_req_if.sv
rtl/ldd_rsp_if.sv
rtl/ldd_csr_if.sv
rtl/ldd_sine_rom.sv
rtl/ldd_divider.sv
rtl/lockin_dither_demodulator.sv
dv/tb_top.sv
